@@ sv/round_robin_task_scheduler_macros.svh @@
// Assertion macros for the round-robin task scheduler.
// Used by the top level only; no other dependencies.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRTS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRTS_ASSERT(label, clk, rst_n, prop, msg)
`define RRTS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ sv/rrts_pkg.sv @@
// Package for the round-robin task scheduler: slot states, modes, statuses,
// the event record passed from front to back, and the divide-by-ten constant.
`timescale 1ns / 1ps
package rrts_pkg;
  localparam int unsigned TaskSlots = 16;
  localparam int unsigned SlotW = $clog2(TaskSlots);
  localparam int unsigned TickMs = 10;
  localparam int unsigned QDepth = 2;
  // 2^35 / 10 rounded up: x / 10 is (x * Recip10) >> 35 for any 32-bit x
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

  typedef enum logic [2:0] {
    ST_FREE = 3'd0, ST_READY = 3'd1, ST_RUNNING = 3'd2,
    ST_BLOCKED = 3'd3, ST_ZOMBIE = 3'd4
  } slot_st_e;

  typedef enum logic [2:0] {
    MD_TICK = 3'd0, MD_PREEMPT = 3'd1, MD_YIELD = 3'd2, MD_SLEEP = 3'd3,
    MD_CREATE = 3'd4, MD_EXIT = 3'd5, MD_KILL = 3'd6, MD_RELEASE = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    STS_OK = 2'd0, STS_NO_SLOT = 2'd1, STS_REFUSED = 2'd2, STS_IDLE_EXIT = 2'd3
  } status_e;

  // Classified event: sleep and deadline intervals already turned into ticks; the CPU limit stays in milliseconds
  typedef struct packed {
    mode_e       mode;
    logic        user_mode;
    logic [31:0] sleep_ticks;
    logic [15:0] task_id;
    logic        user_task;
    logic [31:0] cpu_limit_ms;
    logic        has_deadline;
    logic [31:0] deadline_ticks;
  } event_t;

  typedef struct packed {
    logic [SlotW-1:0] running_slot;
    logic [15:0]      running_id;
    logic [15:0]      created_id;
    status_e          status;
    logic             switched;
    logic             killed_exit;
  } result_t;
endpackage

@@ sv/rrts_div10.sv @@
// Divide-by-ten by multiplying with a scaled reciprocal; the quotient is
// ready in the cycle after start. Depends on rrts_pkg.
`timescale 1ns / 1ps
module rrts_div10 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);
  import rrts_pkg::*;

  logic [63:0] prod_q, prod_d;
  logic        done_q;

  // Scale by the reciprocal; the top bits give the exact quotient
  assign prod_d = {32'd0, dividend_i} * {32'd0, Recip10};

  // Flag the quotient the cycle after start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= start_i;
  end

  // Hold the product until the next start
  always_ff @(posedge clk_i) begin
    if (start_i) prod_q <= prod_d;
  end

  assign done_o     = done_q;
  assign quotient_o = {3'd0, prod_q[63:35]};
endmodule

@@ sv/rrts_front.sv @@
// Front end: accepts event transactions, converts the sleep and deadline
// millisecond fields to ticks with a shared divider and pushes classified
// events into a queue. Depends on rrts_pkg and rrts_div10.
`timescale 1ns / 1ps
module rrts_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           mode_i,
  input  logic                 user_mode_i,
  input  logic [31:0]          sleep_ms_i,
  input  logic [15:0]          task_id_i,
  input  logic                 user_task_i,
  input  logic [31:0]          cpu_limit_ms_i,
  input  logic [31:0]          due_ms_i,
  output logic                 ev_valid_o,
  input  logic                 ev_ready_i,
  output rrts_pkg::event_t     ev_o
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001, F_DIV = 3'b010, F_PUSH = 3'b100
  } fstate_e;

  fstate_e     st_q, st_d;
  event_t      ev_q, ev_d;
  logic        div_start, div_done;
  logic [31:0] div_in, div_quot;
  event_t      q_mem [QDepth];
  logic [$clog2(QDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QDepth):0]   cnt_q;
  logic        push, pop;

  rrts_div10 u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_in),
    .done_o(div_done), .quotient_o(div_quot)
  );

  assign in_ready_o = (st_q == F_IDLE);
  assign div_in = (mode_i == 3'(MD_SLEEP)) ? sleep_ms_i : due_ms_i;

  // Capture the transaction, divide when the mode carries a time
  always_comb begin
    st_d = st_q;
    ev_d = ev_q;
    div_start = 1'b0;
    push = 1'b0;
    case (st_q)
      F_IDLE: begin
        if (in_valid_i) begin
          ev_d.mode           = mode_e'(mode_i);
          ev_d.user_mode      = user_mode_i;
          ev_d.sleep_ticks    = '0;
          ev_d.task_id        = task_id_i;
          ev_d.user_task      = user_task_i;
          ev_d.cpu_limit_ms   = cpu_limit_ms_i;
          ev_d.has_deadline   = (due_ms_i != 32'd0);
          ev_d.deadline_ticks = '0;
          if (mode_i == 3'(MD_SLEEP) || mode_i == 3'(MD_CREATE)) begin
            div_start = 1'b1;
            st_d = F_DIV;
          end else begin
            st_d = F_PUSH;
          end
        end
      end
      F_DIV: begin
        if (div_done) begin
          ev_d.sleep_ticks    = div_quot;
          ev_d.deadline_ticks = div_quot;
          st_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (cnt_q != ($clog2(QDepth)+1)'(QDepth)) begin
          push = 1'b1;
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  // Event queue
  assign pop        = ev_valid_o && ev_ready_i;
  assign ev_valid_o = (cnt_q != '0);
  assign ev_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
    if (push) q_mem[wp_q] <= ev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= F_IDLE;
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(pop);
    end
  end
endmodule

@@ sv/rrts_back.sv @@
// Back end: holds the slot table and carries out one event at a time,
// scanning slots one per cycle for wakeups, kills, free slots, task ids and selection.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
module rrts_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           quantum_ticks_i,
  input  logic                 ev_valid_i,
  output logic                 ev_ready_o,
  input  rrts_pkg::event_t     ev_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output rrts_pkg::result_t    res_o
);
  import rrts_pkg::*;

  typedef enum logic [7:0] {
    B_IDLE   = 8'b00000001,
    B_EXEC   = 8'b00000010,
    B_SCAN   = 8'b00000100,
    B_CHARGE = 8'b00001000,
    B_LIMIT  = 8'b00010000,
    B_SEL    = 8'b00100000,
    B_SWAP   = 8'b01000000,
    B_OUT    = 8'b10000000
  } bstate_e;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TaskSlots - 1);

  // Per-slot registers; each entry is touched at the scan index, the current slot or the selected slot
  slot_st_e    s_st     [TaskSlots];
  logic [15:0] s_id     [TaskSlots];
  logic        s_user   [TaskSlots];
  logic        s_sleep  [TaskSlots];
  logic [31:0] s_wake   [TaskSlots];
  logic [31:0] s_dl     [TaskSlots];
  logic [31:0] s_cpu    [TaskSlots];
  logic [31:0] s_lim    [TaskSlots];
  logic        s_kill   [TaskSlots];
  logic [7:0]  s_quant  [TaskSlots];

  bstate_e          st_q;
  event_t           ev_q;
  logic [SlotW-1:0] cur_q, before_q, idx_q, found_q, next_slot;
  logic             found_v_q, any_ready_q, resched_q;
  logic [31:0]      now_q;
  logic [15:0]      nid_q;
  status_e          sts_q;
  logic [15:0]      created_q;
  logic             kexit_q;
  logic             do_sel_q;
  logic [35:0]      cpu_x10_q;
  logic             res_v_q;
  result_t          res_q;
  logic             lim_hit;

  function automatic logic reached(input logic [31:0] now, input logic [31:0] t);
    logic [31:0] d;
    d = now - t;
    return !d[31];
  endfunction

  assign ev_ready_o  = (st_q == B_IDLE);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  // Round-robin candidate for the selection scan
  logic [SlotW-1:0] cand;
  assign cand = cur_q + idx_q + SlotW'(1);

  // Slot chosen by the selection scan, idle when none is ready
  assign next_slot = found_v_q ? found_q : '0;

  // CPU limit of the running user task reached after this tick's charge
  assign lim_hit = (idx_q == SlotW'(1)) && s_user[cur_q] && s_lim[cur_q] != '0 &&
                   cpu_x10_q >= {4'd0, s_lim[cur_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= B_IDLE;
      cur_q     <= '0;
      resched_q <= 1'b0;
      now_q     <= '0;
      nid_q     <= 16'd1;
      res_v_q   <= 1'b0;
      for (int i = 0; i < TaskSlots; i++) begin
        s_st[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
        s_id[i] <= '0; s_user[i] <= 1'b0; s_sleep[i] <= 1'b0;
        s_wake[i] <= '0; s_dl[i] <= '0; s_cpu[i] <= '0; s_lim[i] <= '0;
        s_kill[i] <= 1'b0; s_quant[i] <= '0;
      end
    end else begin
      if (res_v_q && res_ready_i && st_q != B_OUT) res_v_q <= 1'b0;
      case (st_q)
        // Take the next event from the queue
        B_IDLE: begin
          if (ev_valid_i) begin
            ev_q      <= ev_i;
            before_q  <= cur_q;
            sts_q     <= STS_OK;
            created_q <= '0;
            kexit_q   <= 1'b0;
            do_sel_q  <= 1'b0;
            idx_q     <= '0;
            found_v_q <= 1'b0;
            found_q   <= '0;
            st_q      <= B_EXEC;
            if (ev_i.mode == MD_TICK) now_q <= now_q + 32'd1;
          end
        end
        // Modes that need a scan go there; others act on the current slot
        B_EXEC: begin
          case (ev_q.mode)
            MD_TICK, MD_CREATE, MD_KILL, MD_RELEASE: begin
              idx_q <= (ev_q.mode == MD_KILL || ev_q.mode == MD_RELEASE) ? '0 : SlotW'(1);
              st_q  <= B_SCAN;
            end
            MD_PREEMPT: begin
              if (ev_q.user_mode && s_kill[cur_q] && cur_q != '0) begin
                s_st[cur_q] <= ST_ZOMBIE;
                s_sleep[cur_q] <= 1'b0;
                kexit_q <= 1'b1;
                st_q <= B_SEL;
              end else if (resched_q && (ev_q.user_mode || cur_q == '0)) begin
                resched_q <= 1'b0;
                st_q <= B_SEL;
              end else begin
                st_q <= B_OUT;
              end
              idx_q <= '0;
            end
            MD_YIELD: begin
              s_st[cur_q] <= ST_READY;
              idx_q <= '0;
              st_q <= B_SEL;
            end
            MD_SLEEP: begin
              if (cur_q == '0) begin
                sts_q <= STS_REFUSED;
                st_q <= B_OUT;
              end else begin
                s_wake[cur_q] <= now_q + ev_q.sleep_ticks + 32'd1;
                s_sleep[cur_q] <= 1'b1;
                s_st[cur_q] <= ST_BLOCKED;
                idx_q <= '0;
                st_q <= B_SEL;
              end
            end
            MD_EXIT: begin
              if (cur_q == '0) begin
                sts_q <= STS_IDLE_EXIT;
                st_q <= B_OUT;
              end else begin
                s_st[cur_q] <= ST_ZOMBIE;
                s_sleep[cur_q] <= 1'b0;
                idx_q <= '0;
                st_q <= B_SEL;
              end
            end
            default: st_q <= B_OUT;
          endcase
        end
        // One slot a cycle: wakeups (tick), free search, id search
        B_SCAN: begin
          case (ev_q.mode)
            MD_TICK: begin
              if (s_st[idx_q] == ST_BLOCKED && s_sleep[idx_q] &&
                  reached(now_q, s_wake[idx_q])) begin
                s_sleep[idx_q] <= 1'b0;
                s_st[idx_q] <= ST_READY;
              end
              if (idx_q == LastSlot) begin
                cpu_x10_q <= '0;
                st_q <= B_CHARGE;
              end else idx_q <= idx_q + SlotW'(1);
            end
            MD_CREATE: begin
              if (s_st[idx_q] == ST_FREE) begin
                s_id[idx_q] <= nid_q;
                created_q <= nid_q;
                nid_q <= (nid_q == 16'hFFFF) ? 16'd1 : nid_q + 16'd1;
                s_user[idx_q] <= ev_q.user_task;
                s_sleep[idx_q] <= 1'b0;
                s_wake[idx_q] <= '0;
                s_cpu[idx_q] <= '0;
                s_kill[idx_q] <= 1'b0;
                s_quant[idx_q] <= quantum_ticks_i;
                s_lim[idx_q] <= ev_q.user_task ? ev_q.cpu_limit_ms : '0;
                if (ev_q.user_task && ev_q.has_deadline)
                  s_dl[idx_q] <= ((now_q + ev_q.deadline_ticks + 32'd1) == '0) ? 32'd1
                               : now_q + ev_q.deadline_ticks + 32'd1;
                else s_dl[idx_q] <= '0;
                s_st[idx_q] <= ST_READY;
                st_q <= B_OUT;
              end else if (idx_q == LastSlot) begin
                sts_q <= STS_NO_SLOT;
                st_q <= B_OUT;
              end else idx_q <= idx_q + SlotW'(1);
            end
            default: begin
              if (s_st[idx_q] != ST_FREE && s_id[idx_q] == ev_q.task_id) begin
                st_q <= B_OUT;
                if (idx_q == '0) sts_q <= STS_REFUSED;
                else if (ev_q.mode == MD_KILL) begin
                  if (!s_user[idx_q]) sts_q <= STS_REFUSED;
                  else begin
                    s_kill[idx_q] <= 1'b1;
                    if (s_st[idx_q] == ST_BLOCKED) begin
                      s_sleep[idx_q] <= 1'b0;
                      s_st[idx_q] <= ST_READY;
                    end
                  end
                end else begin
                  if (s_st[idx_q] != ST_ZOMBIE) sts_q <= STS_REFUSED;
                  else begin
                    s_st[idx_q] <= ST_FREE;
                    s_id[idx_q] <= '0; s_user[idx_q] <= 1'b0; s_sleep[idx_q] <= 1'b0;
                    s_wake[idx_q] <= '0; s_dl[idx_q] <= '0; s_cpu[idx_q] <= '0;
                    s_lim[idx_q] <= '0; s_kill[idx_q] <= 1'b0; s_quant[idx_q] <= '0;
                  end
                end
              end else if (idx_q == LastSlot) begin
                sts_q <= STS_REFUSED;
                st_q <= B_OUT;
              end else idx_q <= idx_q + SlotW'(1);
            end
          endcase
        end
        // Charge the running user task, count its quantum down and flag a deadline kill
        B_CHARGE: begin
          if (s_user[cur_q]) begin
            if (s_cpu[cur_q] != 32'hFFFF_FFFF) begin
              s_cpu[cur_q] <= s_cpu[cur_q] + 32'd1;
              cpu_x10_q <= 36'((s_cpu[cur_q] + 32'd1) * 36'd10);
            end else cpu_x10_q <= 36'(s_cpu[cur_q] * 36'd10);
            if (s_dl[cur_q] != '0 && reached(now_q, s_dl[cur_q])) s_kill[cur_q] <= 1'b1;
            if (s_quant[cur_q] != '0) begin
              s_quant[cur_q] <= s_quant[cur_q] - 8'd1;
              if (s_quant[cur_q] == 8'd1) resched_q <= 1'b1;
            end
          end
          idx_q <= SlotW'(1);
          any_ready_q <= 1'b0;
          st_q <= B_LIMIT;
        end
        // Limit check once, alongside deadline kills and a ready check over slots 1 to the last
        B_LIMIT: begin
          if (lim_hit) s_kill[cur_q] <= 1'b1;
          if (s_st[idx_q] != ST_FREE && s_user[idx_q] && s_st[idx_q] != ST_ZOMBIE &&
              s_dl[idx_q] != '0 && reached(now_q, s_dl[idx_q]) && !s_kill[idx_q] &&
              !(lim_hit && idx_q == cur_q)) begin
            s_kill[idx_q] <= 1'b1;
            if (s_st[idx_q] == ST_BLOCKED) begin
              s_sleep[idx_q] <= 1'b0;
              s_st[idx_q] <= ST_READY;
              any_ready_q <= 1'b1;
            end
          end
          if (s_st[idx_q] == ST_READY) any_ready_q <= 1'b1;
          if (idx_q == LastSlot) st_q <= B_SWAP;
          else idx_q <= idx_q + SlotW'(1);
        end
        // Search round-robin for a ready slot
        B_SEL: begin
          if (!found_v_q && cand != '0 && s_st[cand] == ST_READY) begin
            found_v_q <= 1'b1;
            found_q <= cand;
          end
          if (idx_q == LastSlot) begin
            do_sel_q <= 1'b1;
            st_q <= B_SWAP;
          end else idx_q <= idx_q + SlotW'(1);
        end
        // Apply selection, or request one after a tick
        B_SWAP: begin
          if (!do_sel_q) begin
            if (any_ready_q && cur_q == '0) resched_q <= 1'b1;
          end else if (!found_v_q && s_st[cur_q] == ST_RUNNING) begin
            // keep current
          end else begin
            if (next_slot == cur_q) s_st[cur_q] <= ST_RUNNING;
            else begin
              if (s_st[cur_q] == ST_RUNNING) s_st[cur_q] <= ST_READY;
              s_st[next_slot] <= ST_RUNNING;
              s_quant[next_slot] <= quantum_ticks_i;
              cur_q <= next_slot;
            end
          end
          st_q <= B_OUT;
        end
        // Present the result once the output register is free
        B_OUT: begin
          if (!res_v_q || res_ready_i) begin
            res_v_q <= 1'b1;
            res_q.running_slot <= cur_q;
            res_q.running_id   <= s_id[cur_q];
            res_q.created_id   <= created_q;
            res_q.status       <= sts_q;
            res_q.switched     <= (cur_q != before_q);
            res_q.killed_exit  <= kexit_q;
            st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end
endmodule

@@ sv/round_robin_task_scheduler.sv @@
// Top level of the round-robin task scheduler: front end, event queue and
// back end. Depends on rrts_pkg, rrts_front, rrts_back and the macro header.
`timescale 1ns / 1ps
// One event in, one result out. The front end takes a transaction, waits
// for the divide by ten (a reciprocal multiply) on sleep and create, then
// queues the event and is ready again; a full queue holds it. The back end
// picks an event up; a preempt, yield, sleep or exit that reschedules then
// runs the round-robin scan, kill and release search the slots by id,
// create searches for a free slot, refused idle sleeps, idle exits and
// preempts with nothing to do go straight to the result, and a tick makes
// a wakeup pass, a charge and a deadline pass. A result that is not taken
// stalls the back end; the two-entry queue lets the front end go on.
`include "round_robin_task_scheduler_macros.svh"
module round_robin_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic        user_mode_i,
  input  logic [31:0] sleep_ms_i,
  input  logic [15:0] task_id_i,
  input  logic        user_task_i,
  input  logic [31:0] cpu_limit_ms_i,
  input  logic [31:0] due_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  running_slot_o,
  output logic [15:0] running_id_o,
  output logic [15:0] created_id_o,
  output logic [1:0]  status_o,
  output logic        switched_o,
  output logic        killed_exit_o
);
  import rrts_pkg::*;

  logic [7:0] quantum_q;
  logic       ev_valid, ev_ready;
  event_t     ev;
  result_t    res;

  // Hold the quantum register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quantum_q <= 8'd10;
    else if (cfg_we_i) quantum_q <= cfg_wdata_i;
  end

  rrts_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .user_mode_i,
    .sleep_ms_i, .task_id_i, .user_task_i, .cpu_limit_ms_i, .due_ms_i,
    .ev_valid_o(ev_valid), .ev_ready_i(ev_ready), .ev_o(ev)
  );

  rrts_back u_back (
    .clk_i, .rst_ni, .quantum_ticks_i(quantum_q),
    .ev_valid_i(ev_valid), .ev_ready_o(ev_ready), .ev_i(ev),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign running_slot_o = 4'(res.running_slot);
  assign running_id_o   = res.running_id;
  assign created_id_o   = res.created_id;
  assign status_o       = res.status;
  assign switched_o     = res.switched;
  assign killed_exit_o  = res.killed_exit;

  `RRTS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `RRTS_ASSERT(a_kexit_ok, clk_i, rst_ni, out_valid_o && killed_exit_o |-> status_o == STS_OK, "bad status")
  `RRTS_ASSERT(a_create_id, clk_i, rst_ni, out_valid_o && status_o != STS_OK |-> created_id_o == '0, "stray id")
endmodule
